[src/direct_conv2d_engine_top_assert.svh]
// Assertion macros used by the convolution engine sequencer.
`ifndef DIRECT_CONV2D_ENGINE_TOP_ASSERT_SVH
`define DIRECT_CONV2D_ENGINE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DC2D_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DC2D_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/dc2d_pkg.sv]
// Shared constants, types and codes of the direct 2D convolution engine.
`default_nettype none

package dc2d_pkg;

	localparam int MAX_IN_CHANNELS  = 16;
	localparam int MAX_OUT_CHANNELS = 16;
	localparam int MAX_IMAGE_SIDE   = 64;
	localparam int MAX_KERNEL       = 7;

	localparam int IMAGE_DEPTH  = MAX_IN_CHANNELS * MAX_IMAGE_SIDE * MAX_IMAGE_SIDE;
	localparam int WEIGHT_DEPTH = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * MAX_KERNEL * MAX_KERNEL;
	localparam int IMG_AW       = $clog2(IMAGE_DEPTH);
	localparam int WGT_AW       = $clog2(WEIGHT_DEPTH);

	localparam int SAMPLE_W    = 16;
	localparam int RESULT_W    = 48;
	localparam int OP_W        = 2;
	localparam int CFG_DATA_W  = 7;
	localparam int CFG_INDEX_W = 3;

	localparam int IC_W     = 5;
	localparam int OC_W     = 5;
	localparam int SIDE_W   = 7;
	localparam int KERNEL_W = 3;
	localparam int STRIDE_W = 4;

	localparam int IC_CNT_W = (MAX_IN_CHANNELS > 1) ? $clog2(MAX_IN_CHANNELS) : 1;
	localparam int OC_CNT_W = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;
	localparam int POS_W    = (MAX_IMAGE_SIDE > 1) ? $clog2(MAX_IMAGE_SIDE) : 1;
	localparam int POSSUM_W = SIDE_W + 1;
	localparam int ORIGIN_W = $clog2(MAX_IMAGE_SIDE * MAX_IMAGE_SIDE + 1);
	localparam int HW_W     = $clog2(MAX_IMAGE_SIDE * MAX_IMAGE_SIDE + 1);
	localparam int SW_W     = $clog2(((1 << STRIDE_W) - 1) * MAX_IMAGE_SIDE + 1);
	localparam int ICOC_W   = $clog2(MAX_IN_CHANNELS * MAX_OUT_CHANNELS + 1);
	localparam int KK_W     = $clog2(MAX_KERNEL * MAX_KERNEL + 1);
	localparam int WCOUNT_W = $clog2(WEIGHT_DEPTH + 1);
	localparam int ICOUNT_W = $clog2(IMAGE_DEPTH + 1);

	localparam int PRODUCT_W = 2 * SAMPLE_W;
	localparam int ACC_W     = PRODUCT_W + $clog2(MAX_IN_CHANNELS * MAX_KERNEL * MAX_KERNEL) + 1;

	typedef enum logic [OP_W-1:0] {
		OP_WEIGHT  = 2'd0,
		OP_IMAGE   = 2'd1,
		OP_REQUEST = 2'd2
	} op_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_IN_CH  = 3'd0,
		CFG_OUT_CH = 3'd1,
		CFG_HEIGHT = 3'd2,
		CFG_WIDTH  = 3'd3,
		CFG_KERNEL = 3'd4,
		CFG_STRIDE = 3'd5
	} cfg_index_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [IC_W-1:0]     ic;
		logic [OC_W-1:0]     oc;
		logic [SIDE_W-1:0]   h;
		logic [SIDE_W-1:0]   w;
		logic [KERNEL_W-1:0] k;
		logic [STRIDE_W-1:0] s;
		logic [HW_W-1:0]     hw;
		logic [SW_W-1:0]     sw;
		logic [WCOUNT_W-1:0] wcount;
		logic [ICOUNT_W-1:0] icount;
		logic                busy;
		logic                clear;
	} shape_t;

	typedef struct packed {
		logic start;
		logic issue;
	} mac_ctrl_t;

	typedef struct packed {
		logic [RESULT_W-1:0] value;
		logic                last;
		logic                err;
	} result_t;

endpackage

`default_nettype wire

[src/direct_conv2d_engine_top.sv]
// Top level of the direct multi-channel 2D convolution engine.
`default_nettype none

// Streams weights (out-channel, in-channel, row, column) and image samples
// (channel, row, column) in as signed Q8.8, and answers each request with the
// next output value in (out-channel, row, column) order as signed Q32.16, with
// tlast on the final value of the image and tuser set when the kernel is larger
// than the image. One shared multiply-accumulate unit reads one image sample and
// one weight per cycle from the two stores while a request runs; a request that
// hits the shape error skips the walk. After reset and after each configuration
// write, s_tready stays low while the load sizes are recomputed. Reading a store
// entry that was never loaded returns an undefined value.
module direct_conv2d_engine_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [15:0]                      s_tdata,   // [15:0] sample_value
	input  logic [1:0]                       s_tuser,   // [1:0] operation
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [47:0]                      m_tdata,   // [47:0] result_value
	output logic                             m_tlast,
	output logic                             m_tuser,   // [0] shape_error
	input  logic                             cfg_we,
	input  logic [dc2d_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [dc2d_pkg::CFG_DATA_W-1:0]  cfg_data
);

	dc2d_pkg::shape_t    shape;
	dc2d_pkg::mac_ctrl_t mac_ctrl;
	dc2d_pkg::result_t   res;

	logic                                 img_we;
	logic [dc2d_pkg::IMG_AW-1:0]          img_waddr;
	logic                                 wgt_we;
	logic [dc2d_pkg::WGT_AW-1:0]          wgt_waddr;
	logic                                 rd_en;
	logic [dc2d_pkg::IMG_AW-1:0]          img_raddr;
	logic [dc2d_pkg::WGT_AW-1:0]          wgt_raddr;
	logic signed [dc2d_pkg::SAMPLE_W-1:0] img_rdata;
	logic signed [dc2d_pkg::SAMPLE_W-1:0] wgt_rdata;
	logic signed [dc2d_pkg::ACC_W-1:0]    mac_acc;
	logic                                 mac_busy;
	logic                                 out_free;
	logic                                 res_valid;

	logic                                 out_valid_q;
	logic [dc2d_pkg::RESULT_W-1:0]        out_value_q;
	logic                                 out_last_q;
	logic                                 out_err_q;

	dc2d_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.shape     (shape)
	);

	dc2d_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.shape     (shape),
		.in_valid  (s_tvalid),
		.in_op     (s_tuser),
		.in_ready  (s_tready),
		.img_we    (img_we),
		.img_waddr (img_waddr),
		.wgt_we    (wgt_we),
		.wgt_waddr (wgt_waddr),
		.rd_en     (rd_en),
		.img_raddr (img_raddr),
		.wgt_raddr (wgt_raddr),
		.mac_ctrl  (mac_ctrl),
		.mac_busy  (mac_busy),
		.mac_acc   (mac_acc),
		.out_free  (out_free),
		.res_valid (res_valid),
		.res       (res)
	);

	dc2d_store u_store (
		.clk       (clk),
		.img_we    (img_we),
		.img_waddr (img_waddr),
		.wgt_we    (wgt_we),
		.wgt_waddr (wgt_waddr),
		.wdata     (s_tdata),
		.rd_en     (rd_en),
		.img_raddr (img_raddr),
		.wgt_raddr (wgt_raddr),
		.img_rdata (img_rdata),
		.wgt_rdata (wgt_rdata)
	);

	dc2d_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (mac_ctrl),
		.img_rdata (img_rdata),
		.wgt_rdata (wgt_rdata),
		.acc       (mac_acc),
		.busy      (mac_busy)
	);

	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_value_q <= res.value;
			out_last_q  <= res.last;
			out_err_q   <= res.err;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_value_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_err_q;

endmodule

`default_nettype wire

[src/dc2d_cfg.sv]
// Configuration registers with clamping and the registered shape products.
`default_nettype none

module dc2d_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [dc2d_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [dc2d_pkg::CFG_DATA_W-1:0]  cfg_data,
	output dc2d_pkg::shape_t                 shape
);

	logic [dc2d_pkg::IC_W-1:0]     in_ch_q;
	logic [dc2d_pkg::OC_W-1:0]     out_ch_q;
	logic [dc2d_pkg::SIDE_W-1:0]   height_q;
	logic [dc2d_pkg::SIDE_W-1:0]   width_q;
	logic [dc2d_pkg::KERNEL_W-1:0] kernel_q;
	logic [dc2d_pkg::STRIDE_W-1:0] stride_q;
	logic [1:0]                    settle_q;
	logic                          wr_hit;

	logic [dc2d_pkg::IC_W-1:0]     ic;
	logic [dc2d_pkg::OC_W-1:0]     oc;
	logic [dc2d_pkg::SIDE_W-1:0]   h;
	logic [dc2d_pkg::SIDE_W-1:0]   w;
	logic [dc2d_pkg::KERNEL_W-1:0] k;
	logic [dc2d_pkg::STRIDE_W-1:0] s;

	logic [2*dc2d_pkg::SIDE_W-1:0]                     hw_full;
	logic [dc2d_pkg::STRIDE_W+dc2d_pkg::SIDE_W-1:0]    sw_full;
	logic [dc2d_pkg::IC_W+dc2d_pkg::OC_W-1:0]          icoc_full;
	logic [2*dc2d_pkg::KERNEL_W-1:0]                   kk_full;
	logic [dc2d_pkg::ICOC_W+dc2d_pkg::KK_W-1:0]        wcount_full;
	logic [dc2d_pkg::IC_W+dc2d_pkg::HW_W-1:0]          icount_full;

	logic [dc2d_pkg::HW_W-1:0]     hw_s1;
	logic [dc2d_pkg::SW_W-1:0]     sw_s1;
	logic [dc2d_pkg::ICOC_W-1:0]   icoc_s1;
	logic [dc2d_pkg::KK_W-1:0]     kk_s1;
	logic [dc2d_pkg::WCOUNT_W-1:0] wcount_s2;
	logic [dc2d_pkg::ICOUNT_W-1:0] icount_s2;

	always_comb begin
		wr_hit = 1'b0;
		if (cfg_we) begin
			unique case (cfg_index)
				dc2d_pkg::CFG_IN_CH, dc2d_pkg::CFG_OUT_CH, dc2d_pkg::CFG_HEIGHT,
				dc2d_pkg::CFG_WIDTH, dc2d_pkg::CFG_KERNEL, dc2d_pkg::CFG_STRIDE: wr_hit = 1'b1;
				default: wr_hit = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch_q  <= dc2d_pkg::IC_W'(1);
			out_ch_q <= dc2d_pkg::OC_W'(1);
			height_q <= dc2d_pkg::SIDE_W'(8);
			width_q  <= dc2d_pkg::SIDE_W'(8);
			kernel_q <= dc2d_pkg::KERNEL_W'(3);
			stride_q <= dc2d_pkg::STRIDE_W'(1);
			settle_q <= 2'd2;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					dc2d_pkg::CFG_IN_CH:  in_ch_q  <= cfg_data[dc2d_pkg::IC_W-1:0];
					dc2d_pkg::CFG_OUT_CH: out_ch_q <= cfg_data[dc2d_pkg::OC_W-1:0];
					dc2d_pkg::CFG_HEIGHT: height_q <= cfg_data[dc2d_pkg::SIDE_W-1:0];
					dc2d_pkg::CFG_WIDTH:  width_q  <= cfg_data[dc2d_pkg::SIDE_W-1:0];
					dc2d_pkg::CFG_KERNEL: kernel_q <= cfg_data[dc2d_pkg::KERNEL_W-1:0];
					dc2d_pkg::CFG_STRIDE: stride_q <= cfg_data[dc2d_pkg::STRIDE_W-1:0];
					default: ;
				endcase
			end
			if (wr_hit) begin
				settle_q <= 2'd2;
			end else if (settle_q != 2'd0) begin
				settle_q <= settle_q - 2'd1;
			end
		end
	end

	always_comb begin
		priority if (in_ch_q == '0) ic = dc2d_pkg::IC_W'(1);
		else if (in_ch_q > dc2d_pkg::IC_W'(dc2d_pkg::MAX_IN_CHANNELS))
			ic = dc2d_pkg::IC_W'(dc2d_pkg::MAX_IN_CHANNELS);
		else ic = in_ch_q;

		priority if (out_ch_q == '0) oc = dc2d_pkg::OC_W'(1);
		else if (out_ch_q > dc2d_pkg::OC_W'(dc2d_pkg::MAX_OUT_CHANNELS))
			oc = dc2d_pkg::OC_W'(dc2d_pkg::MAX_OUT_CHANNELS);
		else oc = out_ch_q;

		priority if (height_q == '0) h = dc2d_pkg::SIDE_W'(1);
		else if (height_q > dc2d_pkg::SIDE_W'(dc2d_pkg::MAX_IMAGE_SIDE))
			h = dc2d_pkg::SIDE_W'(dc2d_pkg::MAX_IMAGE_SIDE);
		else h = height_q;

		priority if (width_q == '0) w = dc2d_pkg::SIDE_W'(1);
		else if (width_q > dc2d_pkg::SIDE_W'(dc2d_pkg::MAX_IMAGE_SIDE))
			w = dc2d_pkg::SIDE_W'(dc2d_pkg::MAX_IMAGE_SIDE);
		else w = width_q;

		priority if (kernel_q == '0) k = dc2d_pkg::KERNEL_W'(1);
		else if (kernel_q > dc2d_pkg::KERNEL_W'(dc2d_pkg::MAX_KERNEL))
			k = dc2d_pkg::KERNEL_W'(dc2d_pkg::MAX_KERNEL);
		else k = kernel_q;

		s = (stride_q == '0) ? dc2d_pkg::STRIDE_W'(1) : stride_q;
	end

	assign hw_full     = h * w;
	assign sw_full     = s * w;
	assign icoc_full   = ic * oc;
	assign kk_full     = k * k;
	assign wcount_full = icoc_s1 * kk_s1;
	assign icount_full = ic * hw_s1;

	always_ff @(posedge clk) begin
		hw_s1     <= hw_full[dc2d_pkg::HW_W-1:0];
		sw_s1     <= sw_full[dc2d_pkg::SW_W-1:0];
		icoc_s1   <= icoc_full[dc2d_pkg::ICOC_W-1:0];
		kk_s1     <= kk_full[dc2d_pkg::KK_W-1:0];
		wcount_s2 <= wcount_full[dc2d_pkg::WCOUNT_W-1:0];
		icount_s2 <= icount_full[dc2d_pkg::ICOUNT_W-1:0];
	end

	always_comb begin
		shape.ic     = ic;
		shape.oc     = oc;
		shape.h      = h;
		shape.w      = w;
		shape.k      = k;
		shape.s      = s;
		shape.hw     = hw_s1;
		shape.sw     = sw_s1;
		shape.wcount = wcount_s2;
		shape.icount = icount_s2;
		shape.busy   = (settle_q != 2'd0);
		shape.clear  = wr_hit;
	end

endmodule

`default_nettype wire

[src/dc2d_store.sv]
// Image and weight stores, one write and one registered read port each.
`default_nettype none

module dc2d_store (
	input  logic                                 clk,
	input  logic                                 img_we,
	input  logic [dc2d_pkg::IMG_AW-1:0]          img_waddr,
	input  logic                                 wgt_we,
	input  logic [dc2d_pkg::WGT_AW-1:0]          wgt_waddr,
	input  logic signed [dc2d_pkg::SAMPLE_W-1:0] wdata,
	input  logic                                 rd_en,
	input  logic [dc2d_pkg::IMG_AW-1:0]          img_raddr,
	input  logic [dc2d_pkg::WGT_AW-1:0]          wgt_raddr,
	output logic signed [dc2d_pkg::SAMPLE_W-1:0] img_rdata,
	output logic signed [dc2d_pkg::SAMPLE_W-1:0] wgt_rdata
);

	logic signed [dc2d_pkg::SAMPLE_W-1:0] img_mem [dc2d_pkg::IMAGE_DEPTH];
	logic signed [dc2d_pkg::SAMPLE_W-1:0] wgt_mem [dc2d_pkg::WEIGHT_DEPTH];

	always_ff @(posedge clk) begin
		if (img_we) begin
			img_mem[img_waddr] <= wdata;
		end
		if (rd_en) begin
			img_rdata <= img_mem[img_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (wgt_we) begin
			wgt_mem[wgt_waddr] <= wdata;
		end
		if (rd_en) begin
			wgt_rdata <= wgt_mem[wgt_raddr];
		end
	end

endmodule

`default_nettype wire

[src/dc2d_mac.sv]
// Shared multiply-accumulate unit with a registered product.
`default_nettype none

module dc2d_mac (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  dc2d_pkg::mac_ctrl_t                  ctrl,
	input  logic signed [dc2d_pkg::SAMPLE_W-1:0] img_rdata,
	input  logic signed [dc2d_pkg::SAMPLE_W-1:0] wgt_rdata,
	output logic signed [dc2d_pkg::ACC_W-1:0]    acc,
	output logic                                 busy
);

	logic                                  v_s1;
	logic                                  v_s2;
	logic signed [dc2d_pkg::PRODUCT_W-1:0] product_s2;
	logic signed [dc2d_pkg::ACC_W-1:0]     acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= ctrl.issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			product_s2 <= img_rdata * wgt_rdata;
		end
	end

	// The accumulator is wide enough for the largest sum, so it never saturates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctrl.start) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + dc2d_pkg::ACC_W'(product_s2);
		end
	end

	assign acc  = acc_q;
	assign busy = v_s1 | v_s2;

endmodule

`default_nettype wire

[src/dc2d_seq.sv]
// Sequencer: load pointers, window walk, output position counters.
`default_nettype none

`include "direct_conv2d_engine_top_assert.svh"

module dc2d_seq (
	input  logic                              clk,
	input  logic                              arst_n,
	input  dc2d_pkg::shape_t                  shape,
	input  logic                              in_valid,
	input  logic [dc2d_pkg::OP_W-1:0]         in_op,
	output logic                              in_ready,
	output logic                              img_we,
	output logic [dc2d_pkg::IMG_AW-1:0]       img_waddr,
	output logic                              wgt_we,
	output logic [dc2d_pkg::WGT_AW-1:0]       wgt_waddr,
	output logic                              rd_en,
	output logic [dc2d_pkg::IMG_AW-1:0]       img_raddr,
	output logic [dc2d_pkg::WGT_AW-1:0]       wgt_raddr,
	output dc2d_pkg::mac_ctrl_t               mac_ctrl,
	input  logic                              mac_busy,
	input  logic signed [dc2d_pkg::ACC_W-1:0] mac_acc,
	input  logic                              out_free,
	output logic                              res_valid,
	output dc2d_pkg::result_t                 res
);

	dc2d_pkg::state_t state_q;
	dc2d_pkg::state_t state_d;

	logic [dc2d_pkg::WGT_AW-1:0]   wload_q;
	logic [dc2d_pkg::IMG_AW-1:0]   iload_q;
	logic [dc2d_pkg::OC_CNT_W-1:0] m_q;
	logic [dc2d_pkg::POS_W-1:0]    rpos_q;
	logic [dc2d_pkg::POS_W-1:0]    cpos_q;
	logic [dc2d_pkg::ORIGIN_W-1:0] row_origin_q;
	logic [dc2d_pkg::ORIGIN_W-1:0] origin_q;
	logic [dc2d_pkg::WGT_AW-1:0]   wbase_q;

	logic [dc2d_pkg::IC_CNT_W-1:0] c_q;
	logic [dc2d_pkg::KERNEL_W-1:0] p_q;
	logic [dc2d_pkg::KERNEL_W-1:0] q_q;
	logic [dc2d_pkg::IMG_AW-1:0]   chan_addr_q;
	logic [dc2d_pkg::IMG_AW-1:0]   row_addr_q;
	logic [dc2d_pkg::WGT_AW-1:0]   waddr_q;
	logic                          err_q;

	logic                          accept;
	logic                          start;
	logic                          shape_err;
	logic                          c_last;
	logic                          p_last;
	logic                          q_last;
	logic                          m_last;
	logic [dc2d_pkg::OC_W-1:0]     m_ext;
	logic [dc2d_pkg::POSSUM_W-1:0] col_sum;
	logic [dc2d_pkg::POSSUM_W-1:0] row_sum;
	logic                          col_fit;
	logic                          row_fit;
	logic [dc2d_pkg::IMG_AW:0]     iload_inc;
	logic [dc2d_pkg::WGT_AW:0]     wload_inc;
	logic [dc2d_pkg::IMG_AW-1:0]   iload_next;
	logic [dc2d_pkg::WGT_AW-1:0]   wload_next;
	logic [dc2d_pkg::ORIGIN_W-1:0] next_row_origin;

	assign accept    = in_valid && in_ready;
	assign start     = accept && (in_op == dc2d_pkg::OP_REQUEST);
	assign shape_err = (dc2d_pkg::SIDE_W'(shape.k) > shape.h) ||
		(dc2d_pkg::SIDE_W'(shape.k) > shape.w);

	assign c_last = (dc2d_pkg::IC_W'(c_q) == shape.ic - dc2d_pkg::IC_W'(1));
	assign p_last = (p_q == shape.k - dc2d_pkg::KERNEL_W'(1));
	assign q_last = (q_q == shape.k - dc2d_pkg::KERNEL_W'(1));
	assign m_ext  = dc2d_pkg::OC_W'(m_q);
	assign m_last = (m_ext == shape.oc - dc2d_pkg::OC_W'(1));

	assign col_sum = dc2d_pkg::POSSUM_W'(cpos_q) + dc2d_pkg::POSSUM_W'(shape.s) +
		dc2d_pkg::POSSUM_W'(shape.k);
	assign row_sum = dc2d_pkg::POSSUM_W'(rpos_q) + dc2d_pkg::POSSUM_W'(shape.s) +
		dc2d_pkg::POSSUM_W'(shape.k);
	assign col_fit = (col_sum <= dc2d_pkg::POSSUM_W'(shape.w));
	assign row_fit = (row_sum <= dc2d_pkg::POSSUM_W'(shape.h));
	assign next_row_origin = row_origin_q + dc2d_pkg::ORIGIN_W'(shape.sw);

	assign iload_inc  = {1'b0, iload_q} + 1'b1;
	assign wload_inc  = {1'b0, wload_q} + 1'b1;
	assign iload_next = (dc2d_pkg::ICOUNT_W'(iload_inc) >= shape.icount) ? '0 :
		iload_inc[dc2d_pkg::IMG_AW-1:0];
	assign wload_next = (dc2d_pkg::WCOUNT_W'(wload_inc) >= shape.wcount) ? '0 :
		wload_inc[dc2d_pkg::WGT_AW-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dc2d_pkg::ST_IDLE: begin
				if (start) begin
					state_d = shape_err ? dc2d_pkg::ST_FINISH : dc2d_pkg::ST_RUN;
				end
			end
			dc2d_pkg::ST_RUN: begin
				if (q_last && p_last && c_last) begin
					state_d = dc2d_pkg::ST_DRAIN;
				end
			end
			dc2d_pkg::ST_DRAIN: begin
				if (!mac_busy) begin
					state_d = dc2d_pkg::ST_FINISH;
				end
			end
			dc2d_pkg::ST_FINISH: begin
				if (out_free) begin
					state_d = dc2d_pkg::ST_IDLE;
				end
			end
			default: state_d = dc2d_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready       = (state_q == dc2d_pkg::ST_IDLE) && !shape.busy;
		img_we         = accept && (in_op == dc2d_pkg::OP_IMAGE);
		wgt_we         = accept && (in_op == dc2d_pkg::OP_WEIGHT);
		img_waddr      = iload_q;
		wgt_waddr      = wload_q;
		rd_en          = (state_q == dc2d_pkg::ST_RUN);
		img_raddr      = row_addr_q + dc2d_pkg::IMG_AW'(q_q);
		wgt_raddr      = waddr_q;
		mac_ctrl.start = start;
		mac_ctrl.issue = rd_en;
		res_valid      = (state_q == dc2d_pkg::ST_FINISH) && out_free;
		res.value      = err_q ? '0 : dc2d_pkg::RESULT_W'(mac_acc);
		res.last       = err_q || (m_last && !row_fit && !col_fit);
		res.err        = err_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= dc2d_pkg::ST_IDLE;
			wload_q      <= '0;
			iload_q      <= '0;
			m_q          <= '0;
			rpos_q       <= '0;
			cpos_q       <= '0;
			row_origin_q <= '0;
			origin_q     <= '0;
			wbase_q      <= '0;
			c_q          <= '0;
			p_q          <= '0;
			q_q          <= '0;
			chan_addr_q  <= '0;
			row_addr_q   <= '0;
			waddr_q      <= '0;
			err_q        <= 1'b0;
		end else begin
			state_q <= state_d;
			if (shape.clear) begin
				wload_q      <= '0;
				iload_q      <= '0;
				m_q          <= '0;
				rpos_q       <= '0;
				cpos_q       <= '0;
				row_origin_q <= '0;
				origin_q     <= '0;
				wbase_q      <= '0;
			end else begin
				if (img_we) begin
					iload_q <= iload_next;
				end
				if (wgt_we) begin
					wload_q <= wload_next;
				end
				if (start) begin
					err_q       <= shape_err;
					c_q         <= '0;
					p_q         <= '0;
					q_q         <= '0;
					chan_addr_q <= dc2d_pkg::IMG_AW'(origin_q);
					row_addr_q  <= dc2d_pkg::IMG_AW'(origin_q);
					waddr_q     <= wbase_q;
				end
				if (state_q == dc2d_pkg::ST_RUN) begin
					waddr_q <= waddr_q + 1'b1;
					if (!q_last) begin
						q_q <= q_q + 1'b1;
					end else begin
						q_q <= '0;
						if (!p_last) begin
							p_q        <= p_q + 1'b1;
							row_addr_q <= row_addr_q + dc2d_pkg::IMG_AW'(shape.w);
						end else begin
							p_q         <= '0;
							c_q         <= c_q + 1'b1;
							chan_addr_q <= chan_addr_q + dc2d_pkg::IMG_AW'(shape.hw);
							row_addr_q  <= chan_addr_q + dc2d_pkg::IMG_AW'(shape.hw);
						end
					end
				end
				if (res_valid) begin
					if (err_q) begin
						m_q          <= '0;
						rpos_q       <= '0;
						cpos_q       <= '0;
						row_origin_q <= '0;
						origin_q     <= '0;
						wbase_q      <= '0;
					end else if (col_fit) begin
						cpos_q   <= cpos_q + dc2d_pkg::POS_W'(shape.s);
						origin_q <= origin_q + dc2d_pkg::ORIGIN_W'(shape.s);
					end else begin
						cpos_q <= '0;
						if (row_fit) begin
							rpos_q       <= rpos_q + dc2d_pkg::POS_W'(shape.s);
							row_origin_q <= next_row_origin;
							origin_q     <= next_row_origin;
						end else begin
							rpos_q       <= '0;
							row_origin_q <= '0;
							origin_q     <= '0;
							if (m_last) begin
								m_q     <= '0;
								wbase_q <= '0;
							end else begin
								m_q     <= m_q + 1'b1;
								wbase_q <= waddr_q;
							end
						end
					end
				end
			end
		end
	end

	`DC2D_ASSERT_NOW(a_finish_drained, (state_q == dc2d_pkg::ST_FINISH) && !err_q, !mac_busy, "result taken before the accumulator drained")
	`DC2D_ASSERT_NEXT(a_request_runs, start && !shape_err, state_q == dc2d_pkg::ST_RUN, "valid request did not start the walk")
	`DC2D_ASSERT_NOW(a_image_ptr_range, (state_q == dc2d_pkg::ST_IDLE) && !shape.busy, dc2d_pkg::ICOUNT_W'(iload_inc) <= shape.icount, "image load pointer beyond image size")
	`DC2D_ASSERT_NOW(a_out_channel_range, state_q == dc2d_pkg::ST_IDLE, m_ext < shape.oc, "output channel counter out of range")

endmodule

`default_nettype wire
